/* rtl/core/tac_pkg.sv */
// shared types, constants and instruction codes of the tiny accumulator core
package tac_pkg;

    localparam int DATA_W    = 8;
    localparam int ADDR_W    = 8;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int REG_CNT   = 4;
    localparam int REG_IDX_W = $clog2(REG_CNT);

    localparam logic [DATA_W-1:0] HALT_BYTE = 8'h2c;
    localparam logic [1:0]        MISC_ARM  = 2'd0;

    typedef logic [REG_CNT-1:0][DATA_W-1:0] regfile_t;

    typedef enum logic [1:0] {
        CMD_WRITE_PROG = 2'd0,
        CMD_EXEC       = 2'd1,
        CMD_READ_DATA  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        GRP_ALU  = 2'd0,
        GRP_MEM  = 2'd1,
        GRP_JUMP = 2'd2,
        GRP_MISC = 2'd3
    } grp_t;

    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_SUB = 3'd1,
        ALU_OR  = 3'd2,
        ALU_AND = 3'd3,
        ALU_XOR = 3'd4,
        ALU_ASR = 3'd5,
        ALU_SHL = 3'd6,
        ALU_NOP = 3'd7
    } alu_op_t;

    typedef enum logic [1:0] {
        MEM_LOAD  = 2'd0,
        MEM_STORE = 2'd1
    } mem_op_t;

    typedef enum logic [2:0] {
        JC_GT     = 3'd0,
        JC_GE     = 3'd1,
        JC_EQ     = 3'd2,
        JC_LT     = 3'd3,
        JC_LE     = 3'd4,
        JC_NZ     = 3'd5,
        JC_ALWAYS = 3'd6
    } jmp_cond_t;

    // next architectural state and memory requests of one beat
    typedef struct packed {
        logic [ADDR_W-1:0]    pc;
        regfile_t             regs;
        logic                 ul_pend;
        logic [REG_IDX_W-1:0] ul_target;
        logic [DATA_W-1:0]    ins;
        logic                 ins_fetch;
        logic                 a_load;
        logic                 prog_we;
        logic                 data_re;
        logic                 data_we;
        logic [ADDR_W-1:0]    data_addr;
        logic [DATA_W-1:0]    data_wdata;
    } exec_t;

endpackage

/* rtl/core/tac_mem.sv */
// 256 x 8 store with registered read and per-entry valid bits (unwritten reads as zero)
module tac_mem
    import tac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0]    mem_reg [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [DATA_W-1:0]    rdata_reg;
    logic                 rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[addr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

/* rtl/core/tac_exec.sv */
// instruction decode and execute: next state and memory requests for one beat
module tac_exec
    import tac_pkg::*;
(
    input  logic [1:0]           command,
    input  logic [ADDR_W-1:0]    address,
    input  logic [DATA_W-1:0]    write_data,
    input  logic [DATA_W-1:0]    ins,
    input  regfile_t             regs,
    input  logic [ADDR_W-1:0]    pc,
    input  logic                 ul_pend,
    input  logic [REG_IDX_W-1:0] ul_target,
    output exec_t                ex
);

    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] src;
    logic [2:0]        sh;
    logic [DATA_W-1:0] alu_y;
    logic              take;

    assign acc = regs[0];
    assign src = regs[ins[REG_IDX_W-1:0]];

    // negative amounts count as zero, large ones saturate at seven
    always_comb
    begin
        if (src[DATA_W-1])
        begin
            sh = '0;
        end
        else if (src[DATA_W-2:3] != '0)
        begin
            sh = 3'd7;
        end
        else
        begin
            sh = src[2:0];
        end
    end

    always_comb
    begin
        unique case (alu_op_t'(ins[4:2]))
            ALU_ADD: alu_y = acc + src;
            ALU_SUB: alu_y = acc - src;
            ALU_OR:  alu_y = acc | src;
            ALU_AND: alu_y = acc & src;
            ALU_XOR: alu_y = acc ^ src;
            ALU_ASR: alu_y = DATA_W'($signed(acc) >>> sh);
            ALU_SHL: alu_y = acc << sh;
            ALU_NOP: alu_y = acc;
            default: alu_y = acc;
        endcase
    end

    always_comb
    begin
        unique case (jmp_cond_t'(ins[4:2]))
            JC_GT:     take = !acc[DATA_W-1] && (acc != '0);
            JC_GE:     take = !acc[DATA_W-1];
            JC_EQ:     take = (acc == '0);
            JC_LT:     take = acc[DATA_W-1];
            JC_LE:     take = acc[DATA_W-1] || (acc == '0);
            JC_NZ:     take = (acc != '0);
            JC_ALWAYS: take = 1'b1;
            default:   take = 1'b1;
        endcase
    end

    always_comb
    begin
        ex            = '0;
        ex.pc         = pc;
        ex.regs       = regs;
        ex.ul_pend    = ul_pend;
        ex.ul_target  = ul_target;
        ex.ins        = ins;
        ex.data_addr  = src;
        ex.data_wdata = acc;

        unique case (cmd_t'(command))
            CMD_WRITE_PROG:
            begin
                ex.prog_we = 1'b1;
                // writing the byte under the pc replaces the held instruction
                if (address == pc)
                begin
                    ex.ins = write_data;
                end
            end
            CMD_READ_DATA:
            begin
                ex.data_re   = 1'b1;
                ex.data_addr = address;
            end
            CMD_EXEC:
            begin
                ex.ins_fetch = 1'b1;
                if (ins != HALT_BYTE)
                begin
                    ex.pc = pc + 8'd1;
                    if (ul_pend)
                    begin
                        ex.regs[ul_target] = ins;
                        ex.ul_pend         = 1'b0;
                    end
                    else if (ins[DATA_W-1])
                    begin
                        ex.regs[0] = {1'b0, ins[DATA_W-2:0]};
                    end
                    else
                    begin
                        unique case (grp_t'(ins[6:5]))
                            GRP_ALU:
                            begin
                                ex.regs[0] = alu_y;
                            end
                            GRP_MEM:
                            begin
                                if (ins[4])
                                begin
                                    ex.regs[ins[REG_IDX_W-1:0]] = regs[ins[3:2]];
                                end
                                else
                                begin
                                    unique case (mem_op_t'(ins[3:2]))
                                        MEM_LOAD:
                                        begin
                                            ex.data_re = 1'b1;
                                            ex.a_load  = 1'b1;
                                        end
                                        MEM_STORE:
                                        begin
                                            ex.data_we = 1'b1;
                                        end
                                        default:
                                        begin
                                            ex.data_re = 1'b0;
                                        end
                                    endcase
                                end
                            end
                            GRP_JUMP:
                            begin
                                if (take)
                                begin
                                    ex.pc = src;
                                end
                            end
                            GRP_MISC:
                            begin
                                if (ins[3:2] == MISC_ARM)
                                begin
                                    ex.ul_pend   = 1'b1;
                                    ex.ul_target = ins[REG_IDX_W-1:0];
                                end
                            end
                            default:
                            begin
                                ex.ul_pend = ul_pend;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                ex.prog_we = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/tiny_accumulator_cpu_core_unit.sv */
// top level of the tiny accumulator core: state, memories and beat flow
//
//   channel  direction  handshake            payload
//   in       into core  in_valid / in_stall   command, address, write_data
//   out      from core  out_valid / out_stall program_counter, halted, reg_a..reg_d, read_data
//
// one beat accepted per cycle while in_stall is low; each result passes the middle stage
// and the result register; the middle stage waits on the registered reads of the program
// store (next instruction fetch) and the data store (load and read commands)
// reset clears the registers and the valid bits of both stores; no clearing pass is needed
// a stall on out fills the result register, then the middle stage, then raises in_stall
module tiny_accumulator_cpu_core_unit
    import tac_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               command,
    input  logic [ADDR_W-1:0]        address,
    input  logic [DATA_W-1:0]        write_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [ADDR_W-1:0]        program_counter,
    output logic                     halted,
    output logic signed [DATA_W-1:0] reg_a,
    output logic signed [DATA_W-1:0] reg_b,
    output logic signed [DATA_W-1:0] reg_c,
    output logic signed [DATA_W-1:0] reg_d,
    output logic signed [DATA_W-1:0] read_data
);

    // architectural state
    logic [ADDR_W-1:0]    pc_reg,        pc_next;
    regfile_t             regs_reg,      regs_next;
    logic                 ul_pend_reg,   ul_pend_next;
    logic [REG_IDX_W-1:0] ul_target_reg, ul_target_next;

    // instruction under the pc, held so execute never waits on a fetch
    logic [DATA_W-1:0]    ins_reg,       ins_next;
    // the held instruction or A is still arriving from a store read
    logic                 ins_pend_reg,  ins_pend_next;
    logic                 a_pend_reg,    a_pend_next;

    // middle stage: a beat whose store reads land this cycle
    logic                 s1_valid_reg,  s1_valid_next;
    logic                 s1_read_reg,   s1_read_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]    out_pc_reg;
    logic                 out_halted_reg;
    regfile_t             out_regs_reg;
    logic [DATA_W-1:0]    out_rdata_reg;

    logic                 accept;
    logic                 s1_adv;
    logic [DATA_W-1:0]    prog_rdata;
    logic [DATA_W-1:0]    data_rdata;
    logic [DATA_W-1:0]    eff_ins;
    regfile_t             eff_regs;
    exec_t                ex;

    // bypass the store read data that lands this cycle
    assign eff_ins = ins_pend_reg ? prog_rdata : ins_reg;

    always_comb
    begin
        eff_regs = regs_reg;
        if (a_pend_reg)
        begin
            eff_regs[0] = data_rdata;
        end
    end

    // flow control: middle stage moves when the result register is free or draining
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    tac_exec u_exec (
        .command    (command),
        .address    (address),
        .write_data (write_data),
        .ins        (eff_ins),
        .regs       (eff_regs),
        .pc         (pc_reg),
        .ul_pend    (ul_pend_reg),
        .ul_target  (ul_target_reg),
        .ex         (ex)
    );

    // program store: write port for program beats, fetch at the next pc on execute
    tac_mem u_prog_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (accept && ex.prog_we),
        .re    (accept && ex.ins_fetch),
        .addr  (ex.prog_we ? address : ex.pc),
        .wdata (write_data),
        .rdata (prog_rdata)
    );

    // data store: load, store or read beat
    tac_mem u_data_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (accept && ex.data_we),
        .re    (accept && ex.data_re),
        .addr  (ex.data_addr),
        .wdata (ex.data_wdata),
        .rdata (data_rdata)
    );

    always_comb
    begin
        if (accept)
        begin
            pc_next        = ex.pc;
            regs_next      = ex.regs;
            ul_pend_next   = ex.ul_pend;
            ul_target_next = ex.ul_target;
            ins_next       = ex.ins;
            ins_pend_next  = ex.ins_fetch;
            a_pend_next    = ex.a_load;
        end
        else
        begin
            // fold the bypassed values into the registers
            pc_next        = pc_reg;
            regs_next      = eff_regs;
            ul_pend_next   = ul_pend_reg;
            ul_target_next = ul_target_reg;
            ins_next       = eff_ins;
            ins_pend_next  = 1'b0;
            a_pend_next    = 1'b0;
        end
    end

    always_comb
    begin
        s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
        s1_read_next   = accept ? (cmd_t'(command) == CMD_READ_DATA) : s1_read_reg;
        out_valid_next = s1_adv || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            regs_reg      <= '0;
            ul_pend_reg   <= 1'b0;
            ul_target_reg <= '0;
            ins_reg       <= '0;
            ins_pend_reg  <= 1'b0;
            a_pend_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_read_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            regs_reg      <= regs_next;
            ul_pend_reg   <= ul_pend_next;
            ul_target_reg <= ul_target_next;
            ins_reg       <= ins_next;
            ins_pend_reg  <= ins_pend_next;
            a_pend_reg    <= a_pend_next;
            s1_valid_reg  <= s1_valid_next;
            s1_read_reg   <= s1_read_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload: state after the middle-stage beat
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_pc_reg     <= pc_reg;
            out_halted_reg <= (eff_ins == HALT_BYTE);
            out_regs_reg   <= eff_regs;
            out_rdata_reg  <= s1_read_reg ? data_rdata : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign program_counter = out_pc_reg;
    assign halted          = out_halted_reg;
    assign reg_a           = out_regs_reg[0];
    assign reg_b           = out_regs_reg[1];
    assign reg_c           = out_regs_reg[2];
    assign reg_d           = out_regs_reg[3];
    assign read_data       = out_rdata_reg;

endmodule

/* rtl/core/tac_checker.sv */
// port-level checks of the tiny accumulator core, bound to the top level
module tac_checker
    import tac_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic [1:0]               command,
    input logic [ADDR_W-1:0]        address,
    input logic [DATA_W-1:0]        write_data,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [ADDR_W-1:0]        program_counter,
    input logic                     halted,
    input logic signed [DATA_W-1:0] reg_a,
    input logic signed [DATA_W-1:0] reg_b,
    input logic signed [DATA_W-1:0] reg_c,
    input logic signed [DATA_W-1:0] reg_d,
    input logic signed [DATA_W-1:0] read_data
);

    // a stalled command beat stays offered with the same payload
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(command) && $stable(address)
            && $stable(write_data))
        else $error("command payload changed while stalled");

    // a held result beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // a held result beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(program_counter) && $stable(halted)
            && $stable(reg_a) && $stable(reg_b) && $stable(reg_c) && $stable(reg_d)
            && $stable(read_data))
        else $error("result payload changed while stalled");

    // the input side only backs up behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without back pressure from the output");

    // an accepted beat moves from the middle stage into the result register when the output drains
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
        else $error("accepted beat did not reach the output in two cycles");

endmodule

bind tiny_accumulator_cpu_core_unit tac_checker u_tac_checker (.*);
